// ===== src/mipv_pkg.sv =====
// Package for the Merkle inclusion proof verifier: SM3 constants and helpers.
// Used by the interfaces, the SM3 core and the top level. No dependencies.
`timescale 1ns / 1ps
package mipv_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned IndexBitsDefault = 20;
    localparam int unsigned LeafIdxW = 20;
    localparam int unsigned PaddrW = 5;
    localparam int unsigned MsgBits = 512;
    localparam int unsigned HashBytes = 32;
    localparam int unsigned MsgBytes = HashBytes * 2;

    localparam logic [0:0] REQ_LEAF = 1'b0;
    localparam logic [0:0] REQ_SIB  = 1'b1;

    localparam logic [PaddrW-1:0] ADDR_ROOT0 = 5'd0;
    localparam logic [PaddrW-1:0] ADDR_ROOT1 = 5'd8;
    localparam logic [PaddrW-1:0] ADDR_ROOT2 = 5'd16;
    localparam logic [PaddrW-1:0] ADDR_ROOT3 = 5'd24;

    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // Padding block for a 64-byte message.
    localparam logic [511:0] SM3_PAD_BLOCK = {32'h80000000, 448'd0, 32'(MsgBytes * 8)};

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_sm3_ctl;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ===== src/mipv_if.sv =====
// Handshake channels of the Merkle proof verifier: input item and result item.
// Depends on mipv_pkg.
`timescale 1ns / 1ps
interface mipv_in_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [mipv_pkg::WordW-1:0]    data_word;
    logic [1:0]                    word_pos;
    logic [mipv_pkg::LeafIdxW-1:0] leaf_index;
    logic                          last;
    modport source (output valid, req_type, data_word, word_pos, leaf_index, last,
                    input ready);
    modport sink (input valid, req_type, data_word, word_pos, leaf_index, last,
                  output ready);
endinterface

interface mipv_out_if;
    logic valid;
    logic ready;
    logic match;
    modport source (output valid, match, input ready);
    modport sink (input valid, match, output ready);
endinterface

// ===== src/mipv_sm3.sv =====
// Iterative SM3 compression core for one 512-bit block, one round per cycle.
// Expands the message schedule on the fly in a 16-word window. Depends on mipv_pkg.
`timescale 1ns / 1ps
module mipv_sm3 (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_v,
    input  logic [511:0] i_block,
    output logic         o_done,
    output logic [255:0] o_v
);

    logic [31:0]  r_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [255:0] r_v;
    logic [6:0]   r_round;
    logic         r_busy;
    logic         r_done;

    logic [5:0]  k;
    logic [31:0] t_const, ff, gg, ss1, ss2, tt1, tt2, w_new, a12;

    // Round function and next schedule word.
    always_comb begin
        k = r_round[5:0];
        t_const = (k < 6'd16) ? 32'h79CC4519 : 32'h7A879D8A;
        ff = (k < 6'd16) ? (r_a ^ r_b ^ r_c) : ((r_a & r_b) | (r_a & r_c) | (r_b & r_c));
        gg = (k < 6'd16) ? (r_e ^ r_f ^ r_g) : ((r_e & r_f) | (~r_e & r_g));
        a12 = mipv_pkg::rotl(r_a, 5'd12);
        ss1 = mipv_pkg::rotl(a12 + r_e + mipv_pkg::rotl(t_const, k[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        tt1 = ff + r_d + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = gg + r_h + ss1 + r_w[0];
        w_new = mipv_pkg::perm1(r_w[0] ^ r_w[7] ^ mipv_pkg::rotl(r_w[13], 5'd15))
              ^ mipv_pkg::rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    // Control: round counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 7'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 7'd0;
            end else if (r_busy) begin
                if (r_round == 7'd63) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_round <= 7'd0;
                end else begin
                    r_round <= r_round + 7'd1;
                end
            end
        end
    end

    // Working registers and schedule window.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_v;
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= i_v;
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511 - 32*i -: 32];
            end
        end else if (r_busy) begin
            r_a <= tt1;
            r_b <= r_a;
            r_c <= mipv_pkg::rotl(r_b, 5'd9);
            r_d <= r_c;
            r_e <= mipv_pkg::perm0(tt2);
            r_f <= r_e;
            r_g <= mipv_pkg::rotl(r_f, 5'd19);
            r_h <= r_g;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end
    end

    assign o_done = r_done;
    assign o_v    = r_v ^ {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h};

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("sm3 start while busy");
    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && $past(r_round) == 7'd63) else $error("sm3 done early");
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_round == 7'd0) else $error("sm3 round not cleared");
`endif

endmodule

// ===== src/merkle_inclusion_proof_verifier.sv =====
// Top level of the Merkle inclusion proof verifier with SM3 node hashing.
// Depends on mipv_pkg, mipv_if and mipv_sm3.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in): one 64-bit hash word per item, with its type (leaf or
//   sibling), position 0..3, the leaf index and a last flag.
//   Output channel (o_out): one match bit per item flagged last.
//   APB port: four 64-bit root words at byte addresses 0, 8, 16 and 24.
// Item handling:
//   A leaf word or a sibling word at positions 0..2 is stored in its register.
//   A sibling word at position 3 starts two SM3 compressions on the shared
//   round core, 64 rounds each; the second block is started as the first
//   ends, and the new hash is then written back. With a single round unit, no
//   new item is taken until the combine is through. Input ready is low
//   throughout the combine.
//   A result is written into an output register; ready returns while it waits,
//   but an item flagged last is held off until the previous result is taken.
// Reset: synchronous, active low; clears the running hash, index, roots and
//   all control. Sibling words are undefined until written.
// Stall: if the receiver holds ready low, the result stays valid and stable.
module merkle_inclusion_proof_verifier #(
    parameter int unsigned INDEX_BITS = mipv_pkg::IndexBitsDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mipv_in_if.sink                     i_in,
    mipv_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mipv_pkg::PaddrW-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BLK1  = 2'd1;
    localparam logic [1:0] ST_BLK2  = 2'd2;

    // The leaf index keeps only its low INDEX_BITS bits.
    localparam logic [63:0] IdxMask = (64'd1 << INDEX_BITS) - 64'd1;

    logic [1:0]                    r_state;
    logic [63:0]                   r_root [4];
    logic [63:0]                   r_hash [4];
    logic [63:0]                   r_sib  [4];
    logic [mipv_pkg::LeafIdxW-1:0] r_idx;
    logic                          r_last_pend;
    logic                          r_out_valid;
    logic                          r_match;

    logic         in_fire, sm3_start, sm3_done;
    logic [255:0] sm3_v_in, sm3_v_out, cur_hash, sib_hash;
    logic [511:0] sm3_block;
    logic         eq;
    logic         wr_en;

    assign cur_hash = {r_hash[0], r_hash[1], r_hash[2], r_hash[3]};
    assign sib_hash = {r_sib[0], r_sib[1], r_sib[2], r_sib[3]};

    // Ready: idle, and a last item may not overrun a waiting result.
    assign i_in.ready = (r_state == ST_IDLE) && !(i_in.last && r_out_valid);
    assign in_fire    = i_in.valid && i_in.ready;

    // SM3 core hookup: first block is the node pair, second is padding.
    always_comb begin
        sm3_start = 1'b0;
        sm3_v_in  = mipv_pkg::SM3_IV;
        sm3_block = r_idx[0] ? {sib_hash, cur_hash} : {cur_hash, sib_hash};
        if (r_state == ST_BLK1 && sm3_done) begin
            sm3_start = 1'b1;
            sm3_v_in  = sm3_v_out;
            sm3_block = mipv_pkg::SM3_PAD_BLOCK;
        end else if (in_fire && i_in.req_type == mipv_pkg::REQ_SIB
                     && i_in.word_pos == 2'd3) begin
            sm3_start = 1'b1;
            // Sibling word 3 is not yet in r_sib: bypass it.
            if (r_idx[0]) begin
                sm3_block = {r_sib[0], r_sib[1], r_sib[2], i_in.data_word, cur_hash};
            end else begin
                sm3_block = {cur_hash, r_sib[0], r_sib[1], r_sib[2], i_in.data_word};
            end
        end
    end

    mipv_sm3 u_sm3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sm3_start),
        .i_v     (sm3_v_in),
        .i_block (sm3_block),
        .o_done  (sm3_done),
        .o_v     (sm3_v_out)
    );

    // Sequencer for leaf loads, combines and the final compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_last_pend <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_hash[i] <= '0;
            end
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (i_in.req_type == mipv_pkg::REQ_LEAF) begin
                            r_hash[i_in.word_pos] <= i_in.data_word;
                            r_idx <= i_in.leaf_index & IdxMask[mipv_pkg::LeafIdxW-1:0];
                        end else begin
                            r_sib[i_in.word_pos] <= i_in.data_word;
                        end
                        if (sm3_start) begin
                            r_state     <= ST_BLK1;
                            r_last_pend <= i_in.last;
                        end else if (i_in.last) begin
                            r_out_valid <= 1'b1;
                            r_match <= (i_in.req_type == mipv_pkg::REQ_LEAF) ?
                                ({r_hash[0] ^ ((i_in.word_pos == 2'd0) ? (r_hash[0]
                                  ^ i_in.data_word) : 64'd0),
                                  r_hash[1] ^ ((i_in.word_pos == 2'd1) ? (r_hash[1]
                                  ^ i_in.data_word) : 64'd0),
                                  r_hash[2] ^ ((i_in.word_pos == 2'd2) ? (r_hash[2]
                                  ^ i_in.data_word) : 64'd0),
                                  r_hash[3] ^ ((i_in.word_pos == 2'd3) ? (r_hash[3]
                                  ^ i_in.data_word) : 64'd0)}
                                 == {r_root[0], r_root[1], r_root[2], r_root[3]})
                                : eq;
                        end
                    end
                end
                ST_BLK1: begin
                    if (sm3_done) begin
                        r_state <= ST_BLK2;
                    end
                end
                ST_BLK2: begin
                    if (sm3_done) begin
                        for (int i = 0; i < 4; i++) begin
                            r_hash[i] <= sm3_v_out[255 - 64*i -: 64];
                        end
                        r_idx   <= r_idx >> 1;
                        r_state <= ST_IDLE;
                        if (r_last_pend) begin
                            r_out_valid <= 1'b1;
                            r_match <= (sm3_v_out ==
                                {r_root[0], r_root[1], r_root[2], r_root[3]});
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign eq = (cur_hash == {r_root[0], r_root[1], r_root[2], r_root[3]});

    assign o_out.valid = r_out_valid;
    assign o_out.match = r_match;

    // APB register file for the root words.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_root[i] <= '0;
            end
        end else if (wr_en) begin
            unique case (paddr)
                mipv_pkg::ADDR_ROOT0: r_root[0] <= pwdata;
                mipv_pkg::ADDR_ROOT1: r_root[1] <= pwdata;
                mipv_pkg::ADDR_ROOT2: r_root[2] <= pwdata;
                mipv_pkg::ADDR_ROOT3: r_root[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            mipv_pkg::ADDR_ROOT0: prdata = r_root[0];
            mipv_pkg::ADDR_ROOT1: prdata = r_root[1];
            mipv_pkg::ADDR_ROOT2: prdata = r_root[2];
            mipv_pkg::ADDR_ROOT3: prdata = r_root[3];
            default:              prdata = 64'd0;
        endcase
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !i_in.ready) else $error("ready during combine");
    a_done_in_combine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sm3_done |-> r_state == ST_BLK1 || r_state == ST_BLK2)
        else $error("sm3 done outside combine");
    a_idx_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BLK2 && sm3_done |=> r_idx == ($past(r_idx) >> 1))
        else $error("index not halved");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_match))
        else $error("result lost under stall");
`endif

endmodule
